@@ src/assert_macros.svh @@
// assertion macros included by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion on the house clock and reset
`define ASSERT(label, prop, msg) \
  `ASSERT_IMPL(label, clk_i, rst_ni, prop, msg)

`endif

@@ src/utf8d_pkg.sv @@
// types and constants of the utf-8 code point decoder
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned CountW = 3;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [CodeW-1:0]  code_t;
  typedef logic [CountW-1:0] count_t;

  localparam code_t MaxCodeReset = 21'h10FFFF;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_e;

  localparam count_t SeqNone = 3'd0;
  localparam count_t SeqTwo  = 3'd2;
  localparam count_t SeqThree = 3'd3;
  localparam count_t SeqFour = 3'd4;
  localparam count_t CountOne = 3'd1;

endpackage

@@ src/utf8d_byte_if.sv @@
// input channel: one text byte per beat
interface utf8d_byte_if;
  import utf8d_pkg::*;

  logic  valid;
  logic  ready;
  byte_t byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

@@ src/utf8d_cp_if.sv @@
// output channel: one decoded character or error per beat
interface utf8d_cp_if;
  import utf8d_pkg::*;

  logic    valid;
  logic    ready;
  code_t   code_point;
  status_e status;
  count_t  byte_count;

  modport source (output valid, output code_point, output status, output byte_count,
                  input ready);
  modport sink   (input valid, input code_point, input status, input byte_count,
                  output ready);
endinterface

@@ src/utf8_code_point_decoder.sv @@
// utf-8 code point decoder top level
//
//   channel    dir  width              beat
//   byte_i     in   8                  one text byte
//   cp_o       out  21 + 2 + 3         code point, status, byte count
//   max_code   in   21 + write enable  largest four-byte code point
//
// one byte per cycle when ready; a result shows the cycle after its last byte
// the sequence state and the result register are the only stages
// a result waiting on cp_o does not stop byte_i unless it is stalled itself
// asynchronous active-low reset closes any open sequence and empties the result
module utf8_code_point_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               max_code_we_i,
  input  utf8d_pkg::code_t   max_code_i,
  utf8d_byte_if.sink         byte_i,
  utf8d_cp_if.source         cp_o
);
  import utf8d_pkg::*;

  code_t   max_code_q;
  count_t  seq_total_q, seq_total_d;
  count_t  seq_count_q, seq_count_d;
  code_t   partial_q, partial_d;

  logic    out_valid_q;
  code_t   out_code_q;
  status_e out_status_q;
  count_t  out_count_q;

  logic    emit;
  code_t   emit_code;
  status_e emit_status;
  count_t  emit_count;

  logic    accept;
  byte_t   b;
  code_t   partial_next;
  count_t  count_next;

  assign byte_i.ready = !out_valid_q || cp_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;
  assign b            = byte_i.byte_in;

  assign partial_next = {partial_q[CodeW-7:0], b[5:0]};
  assign count_next   = seq_count_q + CountOne;

  always_comb begin
    seq_total_d = seq_total_q;
    seq_count_d = seq_count_q;
    partial_d   = partial_q;
    emit        = 1'b0;
    emit_code   = '0;
    emit_status = STATUS_OK;
    emit_count  = CountOne;
    if (seq_total_q == SeqNone) begin
      priority if (b[7:3] == 5'b11110) begin
        seq_total_d = SeqFour;
        seq_count_d = CountOne;
        partial_d   = code_t'(b[2:0]);
      end else if (b[7:4] == 4'b1110) begin
        seq_total_d = SeqThree;
        seq_count_d = CountOne;
        partial_d   = code_t'(b[3:0]);
      end else if (b[7:5] == 3'b110) begin
        seq_total_d = SeqTwo;
        seq_count_d = CountOne;
        partial_d   = code_t'(b[4:0]);
      end else begin
        emit      = 1'b1;
        emit_code = code_t'(b);
      end
    end else begin
      priority if (b == '0) begin
        seq_total_d = SeqNone;
        seq_count_d = '0;
        partial_d   = '0;
        emit        = 1'b1;
        emit_status = STATUS_MALFORMED;
        emit_count  = seq_count_q;
      end else if (b[7:6] != 2'b10) begin
        seq_total_d = SeqNone;
        seq_count_d = '0;
        partial_d   = '0;
        emit        = 1'b1;
        emit_status = STATUS_MALFORMED;
        emit_count  = count_next;
      end else if (count_next < seq_total_q) begin
        seq_count_d = count_next;
        partial_d   = partial_next;
      end else begin
        seq_total_d = SeqNone;
        seq_count_d = '0;
        partial_d   = '0;
        emit        = 1'b1;
        emit_count  = seq_total_q;
        if (seq_total_q == SeqFour && partial_next > max_code_q) begin
          emit_status = STATUS_RANGE;
        end else begin
          emit_code = partial_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_code_q <= MaxCodeReset;
    end else if (max_code_we_i) begin
      max_code_q <= max_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_total_q <= SeqNone;
      seq_count_q <= '0;
      partial_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        seq_total_q <= seq_total_d;
        seq_count_q <= seq_count_d;
        partial_q   <= partial_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (cp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_code_q   <= emit_code;
      out_status_q <= emit_status;
      out_count_q  <= emit_count;
    end
  end

  assign cp_o.valid      = out_valid_q;
  assign cp_o.code_point = out_code_q;
  assign cp_o.status     = out_status_q;
  assign cp_o.byte_count = out_count_q;

`include "assert_macros.svh"

  `ASSERT(a_seq_total_legal, seq_total_q == SeqNone || seq_total_q == SeqTwo || seq_total_q == SeqThree || seq_total_q == SeqFour, "illegal sequence length")
  `ASSERT(a_seq_count_below_total, seq_total_q != SeqNone |-> seq_count_q != '0 && seq_count_q < seq_total_q, "sequence count out of range")
  `ASSERT(a_closed_is_clear, seq_total_q == SeqNone |-> seq_count_q == '0 && partial_q == '0, "closed sequence holds stale state")
  `ASSERT(a_range_covers_four, cp_o.valid && cp_o.status == STATUS_RANGE |-> cp_o.byte_count == SeqFour, "range error not on four bytes")
  `ASSERT(a_error_code_zero, cp_o.valid && cp_o.status != STATUS_OK |-> cp_o.code_point == '0, "error beat with nonzero code point")

endmodule
